// ===== src/ked_pkg.sv =====
`default_nettype none

package ked_pkg;

  localparam int unsigned KEY_W    = 8;
  localparam int unsigned CODE_W   = 4;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned DB_W     = 8;
  localparam int unsigned CLICK_W  = 8;
  localparam int unsigned SCAN_W   = 8;
  localparam int unsigned PERIOD_W = CNT_W + SCAN_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned MAX_CLICKS = 5;

  localparam int unsigned QUO_W       = 13;
  localparam logic [QUO_W-1:0] LIM_5S      = 13'd5000;
  localparam logic [QUO_W-1:0] LIM_5S_LESS = 13'd4999;
  localparam logic [QUO_W-1:0] LIM_3S_LESS = 13'd2999;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE  = 3'd0,
    CFG_LONG      = 3'd1,
    CFG_HOLD      = 3'd2,
    CFG_CLICK_GAP = 3'd3,
    CFG_SCAN_MS   = 3'd4
  } cfg_idx_t;

  typedef enum logic [CODE_W-1:0] {
    EV_CLICK  = 4'd0,
    EV_LONG   = 4'd1,
    EV_HOLD   = 4'd2,
    EV_UP     = 4'd3,
    EV_DOUBLE = 4'd4,
    EV_HOLD3S = 4'd8,
    EV_HOLD5S = 4'd9
  } evt_t;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_CLICK,
    KIND_LONG,
    KIND_HOLD,
    KIND_UP,
    KIND_GAP_END
  } kind_t;

endpackage

`default_nettype wire

// ===== src/ked_in_if.sv =====
`default_nettype none

interface ked_in_if
  import ked_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_code;

  modport source (output valid, output key_code, input ready);
  modport sink   (input valid, input key_code, output ready);
endinterface

`default_nettype wire

// ===== src/ked_out_if.sv =====
`default_nettype none

interface ked_out_if
  import ked_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              posted;
  logic [CODE_W-1:0] event_code;
  logic [KEY_W-1:0]  event_key;

  modport source (output valid, output posted, output event_code, output event_key,
                  input ready);
  modport sink   (input valid, input posted, input event_code, input event_key,
                  output ready);
endinterface

`default_nettype wire

// ===== src/key_event_detector.sv =====
// Channel   Dir  Payload                               Transaction
// in_if     in   key_code[7:0]                         valid & ready
// out_if    out  posted, event_code[3:0], event_key    valid & ready
// cfg_*     in   cfg_index[2:0], cfg_data[15:0]        cfg_we
//
// One scan tick per cycle while in_if.ready is high; each accepted tick yields
// one result in the following cycle. After reset and after every configuration
// write, in_if.ready stays low while the hold period and the 3 s / 5 s
// thresholds are derived (product, then a quotient bit per cycle over 13 bits).
// A held result stalls input only when out_if.ready is low.
`default_nettype none

module key_event_detector
  import ked_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  ked_in_if.sink                     in_if,
  ked_out_if.source                  out_if,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned REM_W  = PERIOD_W + 1;
  localparam int unsigned STEP_W = $clog2(QUO_W);

  logic [DB_W-1:0]     db_ticks_r;
  logic [CNT_W-1:0]    long_ticks_r;
  logic [CNT_W-1:0]    hold_ticks_r;
  logic [CNT_W-1:0]    gap_ticks_r;
  logic [SCAN_W-1:0]   scan_ms_r;

  logic                busy_r;
  logic                load_r;
  logic [STEP_W-1:0]   step_r;
  logic [PERIOD_W-1:0] period_r;
  logic                per_zero_r;
  logic [REM_W-1:0]    rem5_r, rem5l_r, rem3l_r;
  logic [QUO_W-1:0]    q5_r, q5l_r, q3l_r;
  logic [STEP_W-1:0]   bit_pos;
  logic [CNT_W-1:0]    diff;

  logic [KEY_W-1:0]    db_last_r, db_last_nxt;
  logic [DB_W-1:0]     db_cnt_r, db_cnt_nxt;
  logic [KEY_W-1:0]    stable_r, stable_nxt;
  logic [CNT_W-1:0]    press_r, press_nxt;
  logic [CNT_W-1:0]    gap_r, gap_nxt;
  logic [CNT_W-1:0]    hr_r, hr_nxt;
  logic [CLICK_W-1:0]  cc_r, cc_nxt;
  logic [KEY_W-1:0]    ck_r, ck_nxt;

  logic                out_valid_r;
  logic                out_posted_r, out_posted_nxt;
  logic [CODE_W-1:0]   out_code_r, out_code_nxt;
  logic [KEY_W-1:0]    out_key_r, out_key_nxt;

  logic                in_acc;
  logic [KEY_W-1:0]    k;
  kind_t               kind;
  logic [KEY_W-1:0]    ev_key;
  logic [CNT_W:0]      gap_inc;
  logic [CNT_W-1:0]    press_inc;
  logic [CNT_W-1:0]    hr_inc;
  logic [CLICK_W-1:0]  cc_cap;

  function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0]    rem,
                                              input logic                din,
                                              input logic [PERIOD_W-1:0] den);
    logic [REM_W-1:0] sh;
    logic             ge;
    sh = {rem[REM_W-2:0], din};
    ge = (sh >= {1'b0, den});
    return {ge ? (sh - {1'b0, den}) : sh, ge};
  endfunction

  assign in_acc       = in_if.valid && in_if.ready;
  assign in_if.ready  = !busy_r && (!out_valid_r || out_if.ready);
  assign out_if.valid      = out_valid_r;
  assign out_if.posted     = out_posted_r;
  assign out_if.event_code = out_code_r;
  assign out_if.event_key  = out_key_r;
  assign k       = in_if.key_code;
  assign bit_pos = STEP_W'(QUO_W - 1) - step_r;
  assign diff    = hold_ticks_r - long_ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      db_ticks_r   <= '0;
      long_ticks_r <= CNT_W'(1);
      hold_ticks_r <= CNT_W'(2);
      gap_ticks_r  <= '0;
      scan_ms_r    <= SCAN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE:  db_ticks_r   <= cfg_data[DB_W-1:0];
        CFG_LONG:      long_ticks_r <= cfg_data[CNT_W-1:0];
        CFG_HOLD:      hold_ticks_r <= cfg_data[CNT_W-1:0];
        CFG_CLICK_GAP: gap_ticks_r  <= cfg_data[CNT_W-1:0];
        CFG_SCAN_MS:   scan_ms_r    <= cfg_data[SCAN_W-1:0];
        default: ;
      endcase
    end
  end

  // threshold sequencer: product, then three restoring dividers in step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      load_r <= 1'b1;
      step_r <= '0;
    end else if (cfg_we) begin
      busy_r <= 1'b1;
      load_r <= 1'b1;
      step_r <= '0;
    end else if (load_r) begin
      load_r <= 1'b0;
      step_r <= '0;
    end else if (busy_r) begin
      if (step_r == STEP_W'(QUO_W - 1)) begin
        busy_r <= 1'b0;
      end else begin
        step_r <= step_r + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_r) begin
      period_r   <= PERIOD_W'(diff * scan_ms_r);
      per_zero_r <= (hold_ticks_r <= long_ticks_r) || (scan_ms_r == '0);
      rem5_r  <= '0;
      rem5l_r <= '0;
      rem3l_r <= '0;
      q5_r    <= '0;
      q5l_r   <= '0;
      q3l_r   <= '0;
    end else if (busy_r) begin
      {rem5_r,  q5_r[0]}  <= div_step(rem5_r,  LIM_5S[bit_pos],      period_r);
      {rem5l_r, q5l_r[0]} <= div_step(rem5l_r, LIM_5S_LESS[bit_pos], period_r);
      {rem3l_r, q3l_r[0]} <= div_step(rem3l_r, LIM_3S_LESS[bit_pos], period_r);
      q5_r[QUO_W-1:1]  <= q5_r[QUO_W-2:0];
      q5l_r[QUO_W-1:1] <= q5l_r[QUO_W-2:0];
      q3l_r[QUO_W-1:1] <= q3l_r[QUO_W-2:0];
    end
  end

  always_comb begin
    db_last_nxt = db_last_r;
    db_cnt_nxt  = db_cnt_r;
    stable_nxt  = stable_r;
    press_nxt   = press_r;
    gap_nxt     = gap_r;
    hr_nxt      = hr_r;
    cc_nxt      = cc_r;
    ck_nxt      = ck_r;
    kind        = KIND_NONE;
    ev_key      = '0;
    out_posted_nxt = 1'b0;
    out_code_nxt   = '0;
    out_key_nxt    = '0;
    gap_inc   = {1'b0, gap_r} + (CNT_W+1)'(1);
    press_inc = press_r + CNT_W'(1);
    hr_inc    = (hr_r != '1) ? hr_r + CNT_W'(1) : hr_r;
    cc_cap    = (cc_r > CLICK_W'(MAX_CLICKS)) ? CLICK_W'(MAX_CLICKS) : cc_r;

    if (db_ticks_r != '0 && k != db_last_r) begin
      db_cnt_nxt  = '0;
      db_last_nxt = k;
    end else if (db_cnt_r < db_ticks_r) begin
      db_cnt_nxt = db_cnt_r + DB_W'(1);
    end else begin
      if (k != stable_r) begin
        if (k != '0) begin
          press_nxt = CNT_W'(1);
          gap_nxt   = '0;
        end else begin
          if (press_r >= long_ticks_r) begin
            kind = KIND_UP;
          end else begin
            kind    = KIND_CLICK;
            gap_nxt = CNT_W'(1);
          end
          ev_key = stable_r;
        end
      end else if (k == '0) begin
        if (gap_r != '0) begin
          if (gap_inc > {1'b0, gap_ticks_r}) begin
            kind    = KIND_GAP_END;
            gap_nxt = '0;
          end else begin
            gap_nxt = gap_inc[CNT_W-1:0];
          end
        end
      end else begin
        press_nxt = press_inc;
        if (press_inc == long_ticks_r) begin
          kind = KIND_LONG;
        end else if (press_inc >= hold_ticks_r) begin
          kind      = KIND_HOLD;
          press_nxt = long_ticks_r;
        end
        ev_key = k;
      end
      stable_nxt = k;

      if (kind != KIND_NONE) begin
        out_posted_nxt = 1'b1;
        out_key_nxt    = ev_key;
        ck_nxt         = '0;
        cc_nxt         = '0;
        hr_nxt         = '0;
        case (kind)
          KIND_LONG: begin
            hr_nxt       = CNT_W'(1);
            out_code_nxt = EV_LONG;
          end
          KIND_HOLD: begin
            hr_nxt       = hr_inc;
            out_code_nxt = EV_HOLD;
            if (!per_zero_r) begin
              if (hr_inc > CNT_W'(q5l_r)) begin
                out_code_nxt = EV_HOLD5S;
                hr_nxt       = CNT_W'(q5_r) + CNT_W'(1);
              end else if (hr_inc > CNT_W'(q3l_r)) begin
                out_code_nxt = EV_HOLD3S;
              end
            end
          end
          KIND_UP: begin
            out_code_nxt = EV_UP;
          end
          KIND_CLICK: begin
            out_posted_nxt = 1'b0;
            out_key_nxt    = '0;
            if (ev_key != ck_r) begin
              cc_nxt = CLICK_W'(1);
              ck_nxt = ev_key;
            end else begin
              cc_nxt = (cc_r != '1) ? cc_r + CLICK_W'(1) : cc_r;
              ck_nxt = ck_r;
            end
          end
          KIND_GAP_END: begin
            out_key_nxt = ck_r;
            if (cc_r >= CLICK_W'(2)) begin
              out_code_nxt = EV_DOUBLE + cc_cap[CODE_W-1:0] - CODE_W'(2);
            end else begin
              out_code_nxt = EV_CLICK;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      db_last_r   <= '0;
      db_cnt_r    <= '0;
      stable_r    <= '0;
      press_r     <= '0;
      gap_r       <= '0;
      hr_r        <= '0;
      cc_r        <= '0;
      ck_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      db_last_r   <= db_last_nxt;
      db_cnt_r    <= db_cnt_nxt;
      stable_r    <= stable_nxt;
      press_r     <= press_nxt;
      gap_r       <= gap_nxt;
      hr_r        <= hr_nxt;
      cc_r        <= cc_nxt;
      ck_r        <= ck_nxt;
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_posted_r <= out_posted_nxt;
      out_code_r   <= out_code_nxt;
      out_key_r    <= out_key_nxt;
    end
  end

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !in_if.ready)
    else $error("input taken while thresholds are recomputed");

  a_idle_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_posted_r |-> (out_code_r == '0) && (out_key_r == '0))
    else $error("unposted result carries an event");

  a_quotients_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (q5_r >= q5l_r) && (q5l_r >= q3l_r))
    else $error("hold thresholds out of order");

  a_click_has_key: assert property (@(posedge clk) disable iff (!rst_n)
    cc_r != '0 |-> ck_r != '0)
    else $error("click run without a key");

endmodule

`default_nettype wire
